>>> rtl/cps_pkg.sv
// Shared types, codes and a helper function for the contactor precharge sequencer.
package cps_pkg;

   // Field widths.
   localparam int unsigned SocW     = 8;
   localparam int unsigned HoldW    = 16;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned StatusW  = 4;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_LOW_SOC_THRESHOLD = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NEG_HOLD_MS       = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PRECHARGE_HOLD_MS = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_POS_HOLD_MS       = 3'd3;

   // Register reset values.
   localparam logic [SocW-1:0]  LowSocThresholdRst = 8'd30;
   localparam logic [HoldW-1:0] NegHoldRst         = 16'd100;
   localparam logic [HoldW-1:0] PrechargeHoldRst   = 16'd10000;
   localparam logic [HoldW-1:0] PosHoldRst         = 16'd100;

   // Sequencer states; the code is also the reported status.
   typedef enum logic [StatusW-1:0] {
      ST_INIT         = 4'd0,
      ST_CLOSE_NEG    = 4'd1,
      ST_HOLD_NEG     = 4'd2,
      ST_CLOSE_PRE    = 4'd3,
      ST_HOLD_PRE     = 4'd4,
      ST_CLOSE_POS    = 4'd5,
      ST_HOLD_POS     = 4'd6,
      ST_OPEN_PRE     = 4'd7,
      ST_RUNNING      = 4'd8,
      ST_LOW_SOC      = 4'd9,
      ST_ERR_RUNNING  = 4'd10
   } state_type;

   // Configuration registers as seen by the sequencing logic.
   typedef struct packed {
      logic [SocW-1:0]  low_soc_threshold;
      logic [HoldW-1:0] neg_hold_ms;
      logic [HoldW-1:0] precharge_hold_ms;
      logic [HoldW-1:0] pos_hold_ms;
   } cfg_type;

   // One input sample.
   typedef struct packed {
      logic             startup_request;
      logic [SocW-1:0]  charge_pct;
      logic             precharge_closed;
      logic             positive_closed;
      logic             negative_closed;
      logic [TimeW-1:0] now_ms;
   } sample_type;

   // Contactor commands.
   typedef struct packed {
      logic precharge;
      logic positive;
      logic negative;
   } drive_type;

   // Transition decision from the step logic.
   typedef struct packed {
      logic      take;
      state_type target;
   } step_type;

   // Contactor commands that belong to a state.
   function automatic drive_type state_drive(input state_type st);
      drive_type d;
      d = '0;
      case (st)
         ST_CLOSE_NEG, ST_HOLD_NEG: begin
            d.negative = 1'b1;
         end
         ST_CLOSE_PRE, ST_HOLD_PRE: begin
            d.precharge = 1'b1;
            d.negative  = 1'b1;
         end
         ST_CLOSE_POS, ST_HOLD_POS: begin
            d.precharge = 1'b1;
            d.positive  = 1'b1;
            d.negative  = 1'b1;
         end
         ST_OPEN_PRE, ST_RUNNING: begin
            d.positive = 1'b1;
            d.negative = 1'b1;
         end
         default: begin
            d = '0;
         end
      endcase
      return d;
   endfunction

endpackage

>>> rtl/cps_csr.sv
// Configuration registers of the contactor precharge sequencer.
module cps_csr
   import cps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOW_SOC_THRESHOLD: cfg_in.low_soc_threshold = csr_wdata[SocW-1:0];
            CSR_NEG_HOLD_MS:       cfg_in.neg_hold_ms       = csr_wdata[HoldW-1:0];
            CSR_PRECHARGE_HOLD_MS: cfg_in.precharge_hold_ms = csr_wdata[HoldW-1:0];
            CSR_POS_HOLD_MS:       cfg_in.pos_hold_ms       = csr_wdata[HoldW-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_soc_threshold <= LowSocThresholdRst;
         cfg_ff.neg_hold_ms       <= NegHoldRst;
         cfg_ff.precharge_hold_ms <= PrechargeHoldRst;
         cfg_ff.pos_hold_ms       <= PosHoldRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/cps_step.sv
// Transition logic of the contactor precharge sequencer for one sample.
module cps_step
   import cps_pkg::*;
(
   input  logic             started,
   input  state_type        state_cur,
   input  logic [TimeW-1:0] snapshot,
   input  cfg_type          cfg,
   input  sample_type       sample,
   output step_type         step
);

   logic [TimeW-1:0] elapsed;
   logic             neg_done;
   logic             pre_done;
   logic             pos_done;
   logic             pre;
   logic             pos;
   logic             neg;

   assign pre = sample.precharge_closed;
   assign pos = sample.positive_closed;
   assign neg = sample.negative_closed;

   // Wrap-around elapsed time; a negative difference never meets a hold.
   assign elapsed  = sample.now_ms - snapshot;
   assign neg_done = !elapsed[TimeW-1] &&
                     (elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.neg_hold_ms});
   assign pre_done = !elapsed[TimeW-1] &&
                     (elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.precharge_hold_ms});
   assign pos_done = !elapsed[TimeW-1] &&
                     (elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.pos_hold_ms});

   // Priority: first sample, then low charge, then the per-state step.
   always_comb begin
      step.take   = 1'b0;
      step.target = state_cur;
      if (!started) begin
         step.take   = 1'b1;
         step.target = ST_INIT;
      end else if (sample.charge_pct < cfg.low_soc_threshold) begin
         step.take   = 1'b1;
         step.target = ST_LOW_SOC;
      end else begin
         case (state_cur)
            ST_INIT: begin
               if (sample.startup_request && !pre && !pos && !neg) begin
                  step.take   = 1'b1;
                  step.target = ST_CLOSE_NEG;
               end
            end
            ST_CLOSE_NEG: begin
               if (!pre && !pos && neg) begin
                  step.take   = 1'b1;
                  step.target = ST_HOLD_NEG;
               end
            end
            ST_HOLD_NEG: begin
               if (neg_done) begin
                  step.take   = 1'b1;
                  step.target = ST_CLOSE_PRE;
               end
            end
            ST_CLOSE_PRE: begin
               if (pre && neg && !pos) begin
                  step.take   = 1'b1;
                  step.target = ST_HOLD_PRE;
               end
            end
            ST_HOLD_PRE: begin
               if (pre_done) begin
                  step.take   = 1'b1;
                  step.target = ST_CLOSE_POS;
               end
            end
            // Any sensed closure counts here.
            ST_CLOSE_POS: begin
               if (pre || neg || pos) begin
                  step.take   = 1'b1;
                  step.target = ST_HOLD_POS;
               end
            end
            ST_HOLD_POS: begin
               if (pos_done) begin
                  step.take   = 1'b1;
                  step.target = ST_OPEN_PRE;
               end
            end
            // Precharge open, or either main contactor closed.
            ST_OPEN_PRE: begin
               if (!pre || neg || pos) begin
                  step.take   = 1'b1;
                  step.target = ST_RUNNING;
               end
            end
            default: begin
               step.take   = 1'b0;
               step.target = state_cur;
            end
         endcase
      end
   end

endmodule

>>> rtl/contactor_precharge_sequencer_core.sv
// Top level of the contactor precharge sequencer: sample register, state and result register.
//
//   Channel   Direction  Ports                          Transaction
//   req       in         req_valid/req_stall + fields   one sensor sample
//   rsp       out        rsp_valid/rsp_stall + fields   status and contactor commands
//   csr       in         csr_write/csr_index/csr_wdata  one register write
//
// A sample is registered in the sample register on acceptance and its result then moves
// into the result register; one sample is accepted per cycle while the input is not stalled.
// The sequencer state and transition time update as the sample moves into the
// result register, so the next sample always sees them.
// A stalled result holds the result register and, if the sample register is full,
// stalls the input. Reset is synchronous and restores the register defaults.
module contactor_precharge_sequencer_core
   import cps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_startup_request,
   input  logic [SocW-1:0]     req_charge_pct,
   input  logic                req_precharge_closed,
   input  logic                req_positive_closed,
   input  logic                req_negative_closed,
   input  logic [TimeW-1:0]    req_now_ms,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [StatusW-1:0]  rsp_status,
   output logic                rsp_drive_precharge,
   output logic                rsp_drive_positive,
   output logic                rsp_drive_negative,

   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type          cfg;
   step_type         step;

   logic             smp_valid_ff;
   logic             smp_valid_in;
   sample_type       smp_ff;
   sample_type       smp_in;

   logic             started_ff;
   logic             started_in;
   state_type        state_ff;
   state_type        state_in;
   logic [TimeW-1:0] snap_ff;
   logic [TimeW-1:0] snap_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   state_type        rsp_state_ff;
   state_type        rsp_state_in;
   drive_type        rsp_drive_ff;
   drive_type        rsp_drive_in;

   logic             out_free;
   logic             advance;
   logic             req_take;

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cps_step u_step (
      .started   (started_ff),
      .state_cur (state_ff),
      .snapshot  (snap_ff),
      .cfg       (cfg),
      .sample    (smp_ff),
      .step      (step)
   );

   // Handshake: the result register frees when empty or when taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = smp_valid_ff && out_free;
   assign req_stall = smp_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Sample register.
   always_comb begin
      smp_valid_in = smp_valid_ff;
      smp_in       = smp_ff;
      if (req_take) begin
         smp_valid_in           = 1'b1;
         smp_in.startup_request  = req_startup_request;
         smp_in.charge_pct       = req_charge_pct;
         smp_in.precharge_closed = req_precharge_closed;
         smp_in.positive_closed  = req_positive_closed;
         smp_in.negative_closed  = req_negative_closed;
         smp_in.now_ms           = req_now_ms;
      end else if (advance) begin
         smp_valid_in = 1'b0;
      end
   end

   // Sequencer state and result register.
   always_comb begin
      started_in   = started_ff;
      state_in     = state_ff;
      snap_in      = snap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_state_in = rsp_state_ff;
      rsp_drive_in = rsp_drive_ff;
      if (advance) begin
         started_in = 1'b1;
         if (step.take) begin
            state_in = step.target;
            snap_in  = smp_ff.now_ms;
         end
         rsp_valid_in = 1'b1;
         rsp_state_in = state_in;
         rsp_drive_in = state_drive(state_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         state_ff     <= ST_INIT;
         snap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         started_ff   <= started_in;
         state_ff     <= state_in;
         snap_ff      <= snap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff       <= smp_in;
      rsp_state_ff <= rsp_state_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_state_ff;
   assign rsp_drive_precharge = rsp_drive_ff.precharge;
   assign rsp_drive_positive  = rsp_drive_ff.positive;
   assign rsp_drive_negative  = rsp_drive_ff.negative;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the contactor precharge sequencer core.
`timescale 1ns / 100ps

module testbench
   import cps_pkg::*;
();

   localparam int CYCLE_LIMIT    = 500000;
   localparam int DIRECTED_COUNT = 14;
   localparam int RANDOM_COUNT   = 690;
   localparam int PHASE_LEN      = 40;
   localparam int SETTLE_CYCLES  = 6;

   // An index past the last register; writes to it must be ignored.
   localparam logic [CsrIdxW-1:0] CSR_SPARE = 3'd6;

   // Status and contactor commands of one result transaction.
   typedef struct packed {
      state_type status;
      drive_type drive;
   } sequencer_result_type;

   // One row of the directed table; result is used only when typed is set.
   typedef struct packed {
      logic                 typed;
      sequencer_result_type result;
      sample_type           smp;
   } directed_row_type;

   logic                clock;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic                req_stall;
   logic                req_startup_request  = 1'b0;
   logic [SocW-1:0]     req_charge_pct       = '0;
   logic                req_precharge_closed = 1'b0;
   logic                req_positive_closed  = 1'b0;
   logic                req_negative_closed  = 1'b0;
   logic [TimeW-1:0]    req_now_ms           = '0;
   logic                rsp_valid;
   logic                rsp_stall            = 1'b0;
   logic [StatusW-1:0]  rsp_status;
   logic                rsp_drive_precharge;
   logic                rsp_drive_positive;
   logic                rsp_drive_negative;
   logic                csr_write            = 1'b0;
   logic [CsrIdxW-1:0]  csr_index            = '0;
   logic [CsrDataW-1:0] csr_wdata            = '0;

   // Sequencer shadow state and shadow registers.
   bit               seq_started;
   state_type        seq_state;
   logic [TimeW-1:0] seq_mark_ms;
   cfg_type          seq_cfg;

   sequencer_result_type predicted_commands[$];
   directed_row_type     directed_rows[DIRECTED_COUNT];
   logic [TimeW-1:0]     wall_ms = '0;
   bit                   calm = 1'b0;
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   int                   stall_left = 0;

   contactor_precharge_sequencer_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_startup_request  (req_startup_request),
      .req_charge_pct       (req_charge_pct),
      .req_precharge_closed (req_precharge_closed),
      .req_positive_closed  (req_positive_closed),
      .req_negative_closed  (req_negative_closed),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_drive_precharge  (rsp_drive_precharge),
      .rsp_drive_positive   (rsp_drive_positive),
      .rsp_drive_negative   (rsp_drive_negative),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[contactor_precharge_sequencer_core] ERROR");
         $finish;
      end
   end

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Hold time that applies in a hold state; zero elsewhere.
   function automatic logic [HoldW-1:0] hold_for_state(input state_type st);
      case (st)
         ST_HOLD_NEG: begin
            return seq_cfg.neg_hold_ms;
         end
         ST_HOLD_PRE: begin
            return seq_cfg.precharge_hold_ms;
         end
         ST_HOLD_POS: begin
            return seq_cfg.pos_hold_ms;
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // Elapsed time is a wrapping difference; a negative span never completes a hold.
   function automatic logic hold_elapsed(input logic [TimeW-1:0] now, input logic [HoldW-1:0] hold);
      logic [TimeW-1:0] span;
      span = now - seq_mark_ms;
      return !span[TimeW-1] && (span >= {16'd0, hold});
   endfunction

   // Decides whether a sample causes a transition and where it leads.
   function automatic logic find_target(input sample_type s, output state_type tgt);
      logic take;
      logic pre;
      logic pos;
      logic neg;
      pre  = s.precharge_closed;
      pos  = s.positive_closed;
      neg  = s.negative_closed;
      take = 1'b0;
      tgt  = seq_state;
      if (!seq_started) begin
         take = 1'b1;
         tgt  = ST_INIT;
      end else if (s.charge_pct < seq_cfg.low_soc_threshold) begin
         take = 1'b1;
         tgt  = ST_LOW_SOC;
      end else begin
         case (seq_state)
            ST_INIT: begin
               take = s.startup_request && !pre && !pos && !neg;
               tgt  = take ? ST_CLOSE_NEG : seq_state;
            end
            ST_CLOSE_NEG: begin
               take = !pre && !pos && neg;
               tgt  = take ? ST_HOLD_NEG : seq_state;
            end
            ST_HOLD_NEG: begin
               take = hold_elapsed(s.now_ms, seq_cfg.neg_hold_ms);
               tgt  = take ? ST_CLOSE_PRE : seq_state;
            end
            ST_CLOSE_PRE: begin
               take = pre && neg && !pos;
               tgt  = take ? ST_HOLD_PRE : seq_state;
            end
            ST_HOLD_PRE: begin
               take = hold_elapsed(s.now_ms, seq_cfg.precharge_hold_ms);
               tgt  = take ? ST_CLOSE_POS : seq_state;
            end
            ST_CLOSE_POS: begin
               // Any one contactor seen closed is enough.
               take = pre || pos || neg;
               tgt  = take ? ST_HOLD_POS : seq_state;
            end
            ST_HOLD_POS: begin
               take = hold_elapsed(s.now_ms, seq_cfg.pos_hold_ms);
               tgt  = take ? ST_OPEN_PRE : seq_state;
            end
            ST_OPEN_PRE: begin
               // Precharge open, or either main contactor closed.
               take = !pre || neg || pos;
               tgt  = take ? ST_RUNNING : seq_state;
            end
            default: begin
               take = 1'b0;
            end
         endcase
      end
      return take;
   endfunction

   // Contactor commands per state, as {precharge, positive, negative}.
   function automatic drive_type contactor_commands(input state_type st);
      case (st)
         ST_CLOSE_NEG, ST_HOLD_NEG: begin
            return drive_type'(3'b001);
         end
         ST_CLOSE_PRE, ST_HOLD_PRE: begin
            return drive_type'(3'b101);
         end
         ST_CLOSE_POS, ST_HOLD_POS: begin
            return drive_type'(3'b111);
         end
         ST_OPEN_PRE, ST_RUNNING: begin
            return drive_type'(3'b011);
         end
         default: begin
            return drive_type'(3'b000);
         end
      endcase
   endfunction

   // Moves the shadow sequencer by one sample and gives the result it must report.
   task automatic predict_sequencer(input sample_type s, output sequencer_result_type r);
      state_type tgt;
      if (find_target(s, tgt)) begin
         seq_mark_ms = s.now_ms;
         seq_state   = tgt;
      end
      seq_started = 1'b1;
      r.status    = seq_state;
      r.drive     = contactor_commands(seq_state);
   endtask

   function automatic logic [SocW-1:0] soc_above_threshold();
      return SocW'($urandom_range(255, seq_cfg.low_soc_threshold));
   endfunction

   // Timestamp candidates: small steps, hold boundaries, time running back,
   // spans around half the counter range, and arbitrary values.
   function automatic logic [TimeW-1:0] now_candidate();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         return wall_ms + $urandom_range(0, 300);
      end
      if (r < 7) begin
         return seq_mark_ms + hold_for_state(seq_state) - $urandom_range(0, 2);
      end
      if (r == 7) begin
         return wall_ms - $urandom_range(1, 5000);
      end
      if (r == 8) begin
         return seq_mark_ms + 32'h7FFF_FFFE + $urandom_range(0, 3);
      end
      return $urandom();
   endfunction

   // Random sample that preferably leaves the state unchanged; one attempt gives plain noise.
   function automatic sample_type linger_sample(input int attempts);
      sample_type s;
      state_type  tgt;
      int         i;
      for (i = 0; i < attempts; i++) begin
         s.startup_request = 1'($urandom_range(0, 1));
         s.charge_pct = (seq_state == ST_LOW_SOC) ? SocW'($urandom_range(0, 255)) :
                                                    soc_above_threshold();
         {s.precharge_closed, s.positive_closed, s.negative_closed} = 3'($urandom_range(0, 7));
         s.now_ms = now_candidate();
         if (!find_target(s, tgt) || tgt == seq_state) begin
            break;
         end
      end
      return s;
   endfunction

   // One-step advance sample: feedback follows the commands or is a random advancing set.
   function automatic sample_type advance_sample();
      sample_type s;
      drive_type  fb;
      fb = contactor_commands(seq_state);
      if (seq_state == ST_CLOSE_POS) begin
         fb = drive_type'(3'($urandom_range(1, 7)));
      end else if (seq_state == ST_OPEN_PRE) begin
         do begin
            fb = drive_type'(3'($urandom_range(0, 7)));
         end while (fb.precharge && !fb.positive && !fb.negative);
      end
      s.startup_request  = 1'b1;
      s.charge_pct       = soc_above_threshold();
      s.precharge_closed = fb.precharge;
      s.positive_closed  = fb.positive;
      s.negative_closed  = fb.negative;
      s.now_ms           = wall_ms + $urandom_range(0, 20);
      if (seq_state == ST_HOLD_NEG || seq_state == ST_HOLD_PRE || seq_state == ST_HOLD_POS) begin
         s.now_ms = seq_mark_ms + hold_for_state(seq_state) +
                    ($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
      end
      return s;
   endfunction

   // Sample with a charge under the threshold, everything else random.
   function automatic sample_type low_charge_sample();
      sample_type s;
      s.startup_request = 1'($urandom_range(0, 1));
      s.charge_pct = SocW'($urandom_range(seq_cfg.low_soc_threshold - 1, 0));
      {s.precharge_closed, s.positive_closed, s.negative_closed} = 3'($urandom_range(0, 7));
      s.now_ms = wall_ms + $urandom_range(0, 300);
      return s;
   endfunction

   function automatic directed_row_type make_row(input logic req, input logic [SocW-1:0] soc,
                                                 input logic pre, input logic pos,
                                                 input logic neg,
                                                 input logic [TimeW-1:0] now, input logic typed,
                                                 input state_type st, input logic [2:0] cmd);
      directed_row_type row;
      row.smp.startup_request  = req;
      row.smp.charge_pct       = soc;
      row.smp.precharge_closed = pre;
      row.smp.positive_closed  = pos;
      row.smp.negative_closed  = neg;
      row.smp.now_ms           = now;
      row.typed                = typed;
      row.result.status        = st;
      row.result.drive         = drive_type'(cmd);
      return row;
   endfunction

   // Presents one sample, waits for its transaction and records the expected result.
   task automatic send_sample(input sample_type s, input logic typed,
                              input sequencer_result_type typed_result);
      sequencer_result_type r;
      req_valid            <= 1'b1;
      req_startup_request  <= s.startup_request;
      req_charge_pct       <= s.charge_pct;
      req_precharge_closed <= s.precharge_closed;
      req_positive_closed  <= s.positive_closed;
      req_negative_closed  <= s.negative_closed;
      req_now_ms           <= s.now_ms;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      wall_ms = s.now_ms;
      predict_sequencer(s, r);
      predicted_commands.push_back(typed ? typed_result : r);
   endtask

   task automatic idle_gap();
      int gap;
      gap = pick_gap();
      if (!calm && gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (predicted_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic store_register(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LOW_SOC_THRESHOLD: begin
            seq_cfg.low_soc_threshold = data[SocW-1:0];
         end
         CSR_NEG_HOLD_MS: begin
            seq_cfg.neg_hold_ms = data;
         end
         CSR_PRECHARGE_HOLD_MS: begin
            seq_cfg.precharge_hold_ms = data;
         end
         CSR_POS_HOLD_MS: begin
            seq_cfg.pos_hold_ms = data;
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [CsrDataW-1:0] register_value();
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return CsrDataW'($urandom_range(0, 3000));
         end
         default: begin
            return CsrDataW'($urandom());
         end
      endcase
   endfunction

   // Between phases: drain, then write registers. The first two phases use the extremes.
   task automatic reconfigure(input int phase);
      logic [CsrDataW-1:0] fill;
      settle();
      if (phase < 2) begin
         fill = (phase == 0) ? '1 : '0;
         store_register(CSR_LOW_SOC_THRESHOLD, fill);
         store_register(CSR_NEG_HOLD_MS, fill);
         store_register(CSR_PRECHARGE_HOLD_MS, fill);
         store_register(CSR_POS_HOLD_MS, fill);
      end else begin
         if ($urandom_range(0, 1)) begin
            store_register(CSR_LOW_SOC_THRESHOLD, register_value());
         end
         if ($urandom_range(0, 1)) begin
            store_register(CSR_NEG_HOLD_MS, register_value());
         end
         if ($urandom_range(0, 1)) begin
            store_register(CSR_PRECHARGE_HOLD_MS, register_value());
         end
         if ($urandom_range(0, 1)) begin
            store_register(CSR_POS_HOLD_MS, register_value());
         end
         if (phase == 2 || $urandom_range(0, 3) == 0) begin
            store_register(CSR_SPARE, CsrDataW'($urandom()));
         end
      end
      csr_write <= 1'b0;
      calm      <= ($urandom_range(0, 3) == 0);
   endtask

   // Result side stalls in random stretches, none during a calm phase.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      sequencer_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_commands.size() == 0) begin
            $error("result with none expected: status %0d", rsp_status);
            mismatch_count++;
         end else begin
            want = predicted_commands.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_drive_precharge !== want.drive.precharge) begin
               $error("drive_precharge: expected %0d, got %0d",
                      want.drive.precharge, rsp_drive_precharge);
               mismatch_count++;
            end
            if (rsp_drive_positive !== want.drive.positive) begin
               $error("drive_positive: expected %0d, got %0d",
                      want.drive.positive, rsp_drive_positive);
               mismatch_count++;
            end
            if (rsp_drive_negative !== want.drive.negative) begin
               $error("drive_negative: expected %0d, got %0d",
                      want.drive.negative, rsp_drive_negative);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int         n;
      int         phase;
      int         dwell;
      int         in_state;
      state_type  dwell_state;
      state_type  low_charge_at;
      sample_type s;

      seq_started = 1'b0;
      seq_state   = ST_INIT;
      seq_mark_ms = '0;
      seq_cfg     = {LowSocThresholdRst, NegHoldRst, PrechargeHoldRst, PosHoldRst};

      // Directed walk from reset into the negative hold, register defaults in force.
      directed_rows[0]  = make_row(1'b1, 8'd0,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                   ST_INIT, 3'b000);
      directed_rows[1]  = make_row(1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b1,
                                   ST_INIT, 3'b000);
      directed_rows[2]  = make_row(1'b1, 8'd30,  1'b1, 1'b0, 1'b0, 32'h0000_0001, 1'b1,
                                   ST_INIT, 3'b000);
      directed_rows[3]  = make_row(1'b1, 8'd30,  1'b0, 1'b1, 1'b0, 32'h0000_0002, 1'b1,
                                   ST_INIT, 3'b000);
      directed_rows[4]  = make_row(1'b1, 8'd30,  1'b0, 1'b0, 1'b1, 32'h0000_0003, 1'b1,
                                   ST_INIT, 3'b000);
      directed_rows[5]  = make_row(1'b1, 8'd31,  1'b0, 1'b0, 1'b0, 32'hFFFF_FFF8, 1'b1,
                                   ST_CLOSE_NEG, 3'b001);
      directed_rows[6]  = make_row(1'b0, 8'd255, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF9, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[7]  = make_row(1'b1, 8'd128, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFA, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[8]  = make_row(1'b1, 8'd200, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFB, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[9]  = make_row(1'b0, 8'd77,  1'b0, 1'b0, 1'b1, 32'hFFFF_FFFC, 1'b1,
                                   ST_HOLD_NEG, 3'b001);
      // One short of the hold across the counter wrap, then time running back,
      // then a span of exactly half the counter range.
      directed_rows[10] = make_row(1'b1, 8'd255, 1'b1, 1'b1, 1'b0, 32'h0000_005F, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[11] = make_row(1'b1, 8'd64,  1'b0, 1'b0, 1'b1, 32'hFFFF_FFFB, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[12] = make_row(1'b1, 8'd99,  1'b1, 1'b0, 1'b1, 32'h7FFF_FFFC, 1'b0,
                                   ST_INIT, 3'b000);
      directed_rows[13] = make_row(1'b0, 8'd30,  1'b0, 1'b1, 1'b0, 32'h0000_005E, 1'b0,
                                   ST_INIT, 3'b000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         send_sample(directed_rows[n].smp, directed_rows[n].typed, directed_rows[n].result);
         idle_gap();
      end

      // Random walk along the sequence: dwell in each state, then step on. The drop
      // to low charge usually comes in the running state, sometimes earlier.
      low_charge_at = ($urandom_range(0, 3) == 0) ?
                      state_type'($urandom_range(ST_HOLD_NEG, ST_OPEN_PRE)) : ST_RUNNING;
      dwell_state = seq_state;
      in_state    = 0;
      dwell       = $urandom_range(20, 80);
      phase       = 0;
      for (n = 0; n < RANDOM_COUNT; n++) begin
         if (n % PHASE_LEN == 0) begin
            reconfigure(phase);
            phase++;
         end
         if (seq_state != dwell_state) begin
            dwell_state = seq_state;
            in_state    = 0;
            dwell       = $urandom_range(20, 80);
         end
         if (in_state >= dwell && seq_state == low_charge_at &&
             seq_cfg.low_soc_threshold != 0) begin
            s = low_charge_sample();
         end else if (in_state >= dwell && seq_state != ST_RUNNING &&
                      seq_state != ST_LOW_SOC) begin
            s = advance_sample();
         end else begin
            s = linger_sample(($urandom_range(0, 9) == 0) ? 1 : 8);
         end
         send_sample(s, 1'b0, '0);
         in_state++;
         idle_gap();
      end

      settle();
      if (mismatch_count == 0) begin
         $display("[contactor_precharge_sequencer_core] OK");
      end else begin
         $display("[contactor_precharge_sequencer_core] ERROR");
      end
      $finish;
   end

endmodule
